// ===== sv/stc_pkg.sv =====
// Shared types, sizes and codes of the two-curve strip triangulation block.
package stc_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;
    localparam int ID_BITS    = 12;

    localparam int ADDR_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int PT_BITS    = ID_BITS + 2 * COORD_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int VAL_BITS   = PROD_BITS + 1;

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    // One request to the shared arithmetic unit: twice the signed area of
    // (p, q, r), or the squared distance from p to q when is_dist is set.
    typedef struct packed {
        t_point p;
        t_point q;
        t_point r;
        logic   is_dist;
    } t_calc_req;

endpackage

// ===== sv/stc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/stc_calc.sv =====
// Shared arithmetic unit: registered products, then area or squared distance.
module stc_calc
    import stc_pkg::*;
(
    input  logic                       i_clk,
    input  t_calc_req                  i_req,
    output logic signed [VAL_BITS-1:0] o_value
);

    logic signed [COORD_BITS-1:0] w_px, w_py, w_qx, w_qy, w_rx, w_ry;
    logic signed [DIFF_BITS-1:0]  w_a, w_b, w_c, w_d;
    logic signed [PROD_BITS-1:0]  r_m1, r_m2;
    logic                         r_dist;

    assign w_px = $signed(i_req.p.x);
    assign w_py = $signed(i_req.p.y);
    assign w_qx = $signed(i_req.q.x);
    assign w_qy = $signed(i_req.q.y);
    assign w_rx = $signed(i_req.r.x);
    assign w_ry = $signed(i_req.r.y);

    always_comb begin
        w_a = DIFF_BITS'(w_qx) - DIFF_BITS'(w_px);
        w_c = DIFF_BITS'(w_qy) - DIFF_BITS'(w_py);
        if (i_req.is_dist) begin
            w_b = w_a;
            w_d = w_c;
        end else begin
            w_b = DIFF_BITS'(w_ry) - DIFF_BITS'(w_py);
            w_d = DIFF_BITS'(w_rx) - DIFF_BITS'(w_px);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= w_a * w_b;
        r_m2   <= w_c * w_d;
        r_dist <= i_req.is_dist;
    end

    assign o_value = r_dist ? (VAL_BITS'(r_m1) + VAL_BITS'(r_m2))
                            : (VAL_BITS'(r_m1) - VAL_BITS'(r_m2));

endmodule

// ===== sv/strip_triangulate_two_curves_top.sv =====
// Top level of the two-curve strip triangulation block: stores, sequencer, result port.
//
// A request with func load A or load B writes one point into its curve store; a load into a
// full curve is dropped. A start request walks both curves and emits counter-clockwise
// triangles on the result ports, one strobe of o_valid per triangle, with o_last on the final
// one. The receiver cannot stall the block, so every result must be taken in the cycle it is
// shown. busy stays high from the start until the last triangle is out. After a start the
// block fetches the first two points of each curve. Each triangle then passes through the
// decision, the step and the refetch of the next point (the first triangle skips the
// refetch), plus the issue and check states for every orientation or distance test run
// through the shared arithmetic unit. While both curves still have points, one to six tests
// run; along the fanned tail no test runs. If either curve is empty, a single status result
// with o_status and o_last high follows the start in the next cycle and busy never rises.
// Both counts clear on every start.
module strip_triangulate_two_curves_top
    import stc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [ID_BITS-1:0]    i_vertex_id,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_corner_first,
    output logic [ID_BITS-1:0]    o_corner_second,
    output logic [ID_BITS-1:0]    o_corner_third,
    output logic                  o_status,
    output logic                  o_last
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FETCH0 = 7'b0000010,
        ST_FETCH1 = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_TISSUE = 7'b0010000,
        ST_TCHECK = 7'b0100000,
        ST_STEP   = 7'b1000000
    } t_state;

    // The refill after a step is folded into the decide state through r_refill.

    t_state r_state, n_state;

    logic [CNT_BITS-1:0] r_cnt_a, r_cnt_b;
    logic [CNT_BITS-1:0] r_na, r_nb, n_na, n_nb;
    logic [CNT_BITS-1:0] r_i, r_j, n_i, n_j;
    t_point              r_pa, r_pb, r_pc, r_pd, n_pa, n_pb, n_pc, n_pd;
    logic [2:0]          r_k, n_k;
    logic                r_adv_a, n_adv_a;
    logic                r_refill, n_refill;
    logic signed [VAL_BITS-1:0] r_d1, n_d1;

    logic                r_valid, n_valid;
    logic [ID_BITS-1:0]  r_c0, r_c1, r_c2, n_c0, n_c1, n_c2;
    logic                r_status, n_status, r_last, n_last;

    logic                w_accept;
    logic                w_we_a, w_we_b;
    logic [ADDR_BITS-1:0] w_raddr_a, w_raddr_b;
    logic [PT_BITS-1:0]  w_rdata_a, w_rdata_b;
    t_point              w_pt_in;
    t_calc_req           w_req;
    logic signed [VAL_BITS-1:0] w_value;

    logic [CNT_BITS:0]   w_i1, w_j1, w_i2, w_j2, w_na, w_nb;
    logic [CNT_BITS-1:0] w_i2n, w_j2n;
    logic                w_more_a, w_more_b;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_pt_in = '{id: i_vertex_id, x: i_coord_x, y: i_coord_y};
    assign w_we_a  = w_accept && (i_func == FUNC_LOAD_A) &&
                     (r_cnt_a < CNT_BITS'(MAX_POINTS));
    assign w_we_b  = w_accept && (i_func == FUNC_LOAD_B) &&
                     (r_cnt_b < CNT_BITS'(MAX_POINTS));

    stc_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (w_we_a),
        .i_waddr(r_cnt_a[ADDR_BITS-1:0]),
        .i_wdata(w_pt_in),
        .i_raddr(w_raddr_a),
        .o_rdata(w_rdata_a)
    );

    stc_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (w_we_b),
        .i_waddr(r_cnt_b[ADDR_BITS-1:0]),
        .i_wdata(w_pt_in),
        .i_raddr(w_raddr_b),
        .o_rdata(w_rdata_b)
    );

    stc_calc u_calc (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_value(w_value)
    );

    // Index arithmetic one bit wider than the counts so that nothing wraps.
    assign w_na  = {1'b0, r_na};
    assign w_nb  = {1'b0, r_nb};
    assign w_i1  = {1'b0, r_i} + (CNT_BITS+1)'(1);
    assign w_j1  = {1'b0, r_j} + (CNT_BITS+1)'(1);
    assign w_i2  = {1'b0, r_i} + (CNT_BITS+1)'(2);
    assign w_j2  = {1'b0, r_j} + (CNT_BITS+1)'(2);
    assign w_i2n = w_i2[CNT_BITS-1:0];
    assign w_j2n = w_j2[CNT_BITS-1:0];
    assign w_more_a = (w_i1 < w_na);
    assign w_more_b = (w_j1 < w_nb);

    // Operand selection for the arithmetic unit, in the order the tests run.
    always_comb begin
        w_req = '{p: r_pa, q: r_pb, r: r_pc, is_dist: 1'b0};
        case (r_k)
            3'd0: w_req = '{p: r_pa, q: r_pb, r: r_pc, is_dist: 1'b0};
            3'd1: w_req = '{p: r_pa, q: r_pb, r: r_pd, is_dist: 1'b0};
            3'd2: w_req = '{p: r_pc, q: r_pb, r: r_pd, is_dist: 1'b0};
            3'd3: w_req = '{p: r_pa, q: r_pd, r: r_pc, is_dist: 1'b0};
            3'd4: w_req = '{p: r_pb, q: r_pc, r: r_pb, is_dist: 1'b1};
            3'd5: w_req = '{p: r_pa, q: r_pd, r: r_pa, is_dist: 1'b1};
            default: w_req = '{p: r_pa, q: r_pb, r: r_pc, is_dist: 1'b0};
        endcase
    end

    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        if (r_state == ST_FETCH0) begin
            w_raddr_a = ADDR_BITS'(1);
            w_raddr_b = ADDR_BITS'(1);
        end else if (r_state == ST_STEP) begin
            w_raddr_a = w_i2n[ADDR_BITS-1:0];
            w_raddr_b = w_j2n[ADDR_BITS-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_na     = r_na;
        n_nb     = r_nb;
        n_i      = r_i;
        n_j      = r_j;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_pc     = r_pc;
        n_pd     = r_pd;
        n_k      = r_k;
        n_adv_a  = r_adv_a;
        n_refill = 1'b0;
        n_d1     = r_d1;
        n_valid  = 1'b0;
        n_c0     = r_c0;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_status = r_status;
        n_last   = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_func == FUNC_START)) begin
                    n_na = r_cnt_a;
                    n_nb = r_cnt_b;
                    n_i  = '0;
                    n_j  = '0;
                    if ((r_cnt_a == '0) || (r_cnt_b == '0)) begin
                        // An empty curve gives one status result and no walk.
                        n_valid  = 1'b1;
                        n_c0     = '0;
                        n_c1     = '0;
                        n_c2     = '0;
                        n_status = 1'b1;
                        n_last   = 1'b1;
                    end else begin
                        n_state = ST_FETCH0;
                    end
                end
            end
            ST_FETCH0: begin
                n_pa    = t_point'(w_rdata_a);
                n_pb    = t_point'(w_rdata_b);
                n_state = ST_FETCH1;
            end
            ST_FETCH1: begin
                n_pc    = t_point'(w_rdata_a);
                n_pd    = t_point'(w_rdata_b);
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_refill) begin
                    // The point fetched during the step arrives now.
                    if (r_adv_a) begin
                        n_pc = t_point'(w_rdata_a);
                    end else begin
                        n_pd = t_point'(w_rdata_b);
                    end
                    n_state = ST_DECIDE;
                end else if (w_more_a && w_more_b) begin
                    n_k     = 3'd0;
                    n_state = ST_TISSUE;
                end else if (w_more_a) begin
                    n_adv_a = 1'b1;
                    n_state = ST_STEP;
                end else if (w_more_b) begin
                    n_adv_a = 1'b0;
                    n_state = ST_STEP;
                end else begin
                    // Both curves hold a single point: no triangle exists.
                    n_state = ST_IDLE;
                end
            end
            ST_TISSUE: begin
                n_state = ST_TCHECK;
            end
            ST_TCHECK: begin
                n_state = ST_TISSUE;
                n_k     = r_k + 3'd1;
                case (r_k)
                    3'd0: begin
                        if (w_value[VAL_BITS-1]) begin
                            n_adv_a = 1'b0;
                            n_state = ST_STEP;
                        end
                    end
                    3'd1, 3'd2: begin
                        if (w_value[VAL_BITS-1]) begin
                            n_adv_a = 1'b1;
                            n_state = ST_STEP;
                        end
                    end
                    3'd3: begin
                        if (w_value[VAL_BITS-1]) begin
                            n_adv_a = 1'b0;
                            n_state = ST_STEP;
                        end
                    end
                    3'd4: begin
                        n_d1 = w_value;
                    end
                    default: begin
                        // Shorter diagonal wins; a tie advances curve B.
                        n_adv_a = (r_d1 < w_value);
                        n_state = ST_STEP;
                    end
                endcase
            end
            ST_STEP: begin
                n_valid  = 1'b1;
                n_status = 1'b0;
                n_c0     = r_pa.id;
                n_c1     = r_pb.id;
                n_refill = 1'b1;
                if (r_adv_a) begin
                    n_c2   = r_pc.id;
                    n_pa   = r_pc;
                    n_i    = w_i1[CNT_BITS-1:0];
                    n_last = !((w_i2 < w_na) || w_more_b);
                end else begin
                    n_c2   = r_pd.id;
                    n_pb   = r_pd;
                    n_j    = w_j1[CNT_BITS-1:0];
                    n_last = !(w_more_a || (w_j2 < w_nb));
                end
                n_state = n_last ? ST_IDLE : ST_DECIDE;
                if (n_last) begin
                    n_refill = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_valid  <= 1'b0;
            r_refill <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_refill <= n_refill;
            if (w_accept && (i_func == FUNC_START)) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                if (w_we_a) begin
                    r_cnt_a <= r_cnt_a + CNT_BITS'(1);
                end
                if (w_we_b) begin
                    r_cnt_b <= r_cnt_b + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_i      <= n_i;
        r_j      <= n_j;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_pc     <= n_pc;
        r_pd     <= n_pd;
        r_k      <= n_k;
        r_adv_a  <= n_adv_a;
        r_d1     <= n_d1;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_c2     <= n_c2;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_corner_first  = r_c0;
    assign o_corner_second = r_c1;
    assign o_corner_third  = r_c2;
    assign o_status        = r_status;
    assign o_last          = r_last;

    // A status result is always the only and final result of its start.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> r_last)
        else $error("status result without last");

    // Every step produces a result in the following cycle.
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |=> r_valid)
        else $error("step without result");

    // The walk never runs past the end of either curve.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TISSUE) |-> (w_more_a && w_more_b))
        else $error("test issued with a curve used up");

    // The last result returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_state == ST_IDLE))
        else $error("busy after last result");

endmodule
